>>> design/lbbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and codes for the label bounding box tracker.
// Used by the core and by its port checker; depends on nothing.
package lbbt_pkg;

  localparam int COORD_W = 6;
  localparam int LABEL_W = 8;
  localparam int SIZE_W  = 7;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } reg_idx_t;

  typedef struct packed {
    action_t              action;
    logic [LABEL_W-1:0]   label;
  } in_item_t;

  typedef struct packed {
    logic                 seen;
    logic                 floating;
    logic [COORD_W-1:0]   min_x;
    logic [COORD_W-1:0]   min_y;
    logic [COORD_W-1:0]   min_z;
    logic [COORD_W-1:0]   max_x;
    logic [COORD_W-1:0]   max_y;
    logic [COORD_W-1:0]   max_z;
  } out_item_t;

endpackage : lbbt_pkg
`default_nettype wire

>>> design/lbbt_bounds_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Simple dual-port RAM holding the per-label bounds, one write and one
// registered read per cycle. Standalone; no package dependency.
module lbbt_bounds_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 36
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : lbbt_bounds_ram
`default_nettype wire

>>> design/label_bounding_box_tracker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// The core takes one word per clock: busy is never asserted, so start alone
// paces the stream. A sample updates the label's bounds and a clear resets the
// seen flags and the scan counters with no sweep. A query word produces its
// result on out_item with out_strobe high for one cycle, passing through stage
// 1 and the output register; the strobe cannot be held off, so the receiver
// must take it then. The rate of one word per cycle is set by the bounds RAM:
// each word does one read-modify-write, reading at acceptance and writing back
// from stage 1, with the last write forwarded to the next word.
module label_bounding_box_tracker_core
  import lbbt_pkg::*;
#(
  parameter int MAX_DIM    = 64,
  parameter int NUM_LABELS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_item_t          in_item,
  output logic                   out_strobe,
  output out_item_t              out_item,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int EW = $clog2(MAX_DIM + 1);
  localparam int LW = $clog2(NUM_LABELS);
  localparam int XW = (CW > COORD_W) ? CW : COORD_W;

  typedef logic [5:0][CW-1:0] entry_t;  // [0..2] min x,y,z, [3..5] max x,y,z
  typedef logic [2:0][CW-1:0] pos_t;

  function automatic logic [COORD_W-1:0] coord_out(input logic [CW-1:0] c);
    logic [XW-1:0] t;
    t = XW'(c);
    return t[COORD_W-1:0];
  endfunction

  // Configuration registers.
  logic [SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_W'(64);
      size_y_r <= SIZE_W'(64);
      size_z_r <= SIZE_W'(64);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SIZE_X: size_x_r <= pwdata[SIZE_W-1:0];
        REG_SIZE_Y: size_y_r <= pwdata[SIZE_W-1:0];
        REG_SIZE_Z: size_z_r <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SIZE_X: prdata = CFG_DW'(size_x_r);
      REG_SIZE_Y: prdata = CFG_DW'(size_y_r);
      REG_SIZE_Z: prdata = CFG_DW'(size_z_r);
      default:    prdata = '0;
    endcase
  end

  // Effective extents: zero acts as one, anything above MAX_DIM as MAX_DIM.
  logic [EW-1:0] eff_x, eff_y, eff_z;

  always_comb begin
    if (size_x_r == '0)              eff_x = EW'(1);
    else if (32'(size_x_r) > MAX_DIM) eff_x = EW'(MAX_DIM);
    else                             eff_x = EW'(size_x_r);
    if (size_y_r == '0)              eff_y = EW'(1);
    else if (32'(size_y_r) > MAX_DIM) eff_y = EW'(MAX_DIM);
    else                             eff_y = EW'(size_y_r);
    if (size_z_r == '0)              eff_z = EW'(1);
    else if (32'(size_z_r) > MAX_DIM) eff_z = EW'(MAX_DIM);
    else                             eff_z = EW'(size_z_r);
  end

  // Acceptance and scan counters.
  logic          accept;
  logic [CW-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [CW-1:0] pos_x_nxt, pos_y_nxt, pos_z_nxt;
  logic [EW-1:0] y_inc, x_inc, z_inc;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    y_inc     = EW'(pos_y_r) + EW'(1);
    x_inc     = EW'(pos_x_r) + EW'(1);
    z_inc     = EW'(pos_z_r) + EW'(1);
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    pos_z_nxt = pos_z_r;
    if (accept && in_item.action == ACT_SAMPLE) begin
      if (y_inc >= eff_y) begin
        pos_y_nxt = '0;
        if (x_inc >= eff_x) begin
          pos_x_nxt = '0;
          pos_z_nxt = (z_inc >= eff_z) ? '0 : CW'(z_inc);
        end else begin
          pos_x_nxt = CW'(x_inc);
        end
      end else begin
        pos_y_nxt = CW'(y_inc);
      end
    end else if (accept && in_item.action == ACT_CLEAR) begin
      pos_x_nxt = '0;
      pos_y_nxt = '0;
      pos_z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      pos_z_r <= '0;
    end else begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      pos_z_r <= pos_z_nxt;
    end
  end

  // Stage 1 holds the accepted word and the position it was sampled at.
  logic               s1_valid_r;
  action_t            s1_action_r;
  logic [LABEL_W-1:0] s1_label_r;
  pos_t               s1_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action_r <= in_item.action;
      s1_label_r  <= in_item.label;
      s1_pos_r    <= {pos_z_r, pos_y_r, pos_x_r};
    end
  end

  // Bounds RAM, read at acceptance, written back from stage 1.
  logic            ram_we;
  logic [LW-1:0]   s1_idx;
  entry_t          ram_rdata;
  entry_t          merged;

  lbbt_bounds_ram #(
    .DEPTH (NUM_LABELS),
    .WIDTH (6 * CW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_idx),
    .wdata (merged),
    .re    (accept),
    .raddr (in_item.label[LW-1:0]),
    .rdata (ram_rdata)
  );

  logic [NUM_LABELS-1:0]  seen_r;
  logic                   byp_valid_r;
  logic [LW-1:0]          byp_idx_r;
  entry_t                 byp_data_r;
  logic                   s1_lab_ok, s1_seen;
  entry_t                 cur;

  assign s1_idx    = s1_label_r[LW-1:0];
  assign s1_lab_ok = (s1_label_r != '0) && (32'(s1_label_r) < NUM_LABELS);
  assign s1_seen   = s1_lab_ok && seen_r[s1_idx];
  // The RAM read missed a write made at the same edge; take that write instead.
  assign cur       = (byp_valid_r && byp_idx_r == s1_idx) ? byp_data_r : ram_rdata;
  assign ram_we    = s1_valid_r && s1_action_r == ACT_SAMPLE && s1_lab_ok;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (!s1_seen) begin
        merged[a]     = s1_pos_r[a];
        merged[a + 3] = s1_pos_r[a];
      end else begin
        merged[a]     = (s1_pos_r[a] < cur[a])     ? s1_pos_r[a] : cur[a];
        merged[a + 3] = (s1_pos_r[a] > cur[a + 3]) ? s1_pos_r[a] : cur[a + 3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      byp_valid_r <= 1'b0;
    end else begin
      byp_valid_r <= ram_we;
      if (s1_valid_r && s1_action_r == ACT_CLEAR) begin
        seen_r <= '0;
      end else if (ram_we) begin
        seen_r[s1_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      byp_idx_r  <= s1_idx;
      byp_data_r <= merged;
    end
  end

  // Query result.
  logic      out_strobe_r;
  out_item_t out_item_r, out_item_nxt;
  logic      touch;

  always_comb begin
    touch = (cur[0] == '0) || (cur[1] == '0) || (cur[2] == '0) ||
            (EW'(cur[3]) == eff_x - EW'(1)) ||
            (EW'(cur[4]) == eff_y - EW'(1)) ||
            (EW'(cur[5]) == eff_z - EW'(1));
    out_item_nxt = '0;
    if (s1_seen) begin
      out_item_nxt.seen     = 1'b1;
      out_item_nxt.floating = !touch;
      out_item_nxt.min_x    = coord_out(cur[0]);
      out_item_nxt.min_y    = coord_out(cur[1]);
      out_item_nxt.min_z    = coord_out(cur[2]);
      out_item_nxt.max_x    = coord_out(cur[3]);
      out_item_nxt.max_y    = coord_out(cur[4]);
      out_item_nxt.max_z    = coord_out(cur[5]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s1_valid_r && s1_action_r == ACT_QUERY;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule : label_bounding_box_tracker_core
`default_nettype wire

>>> design/lbbt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for the tracker core, attached to it by the bind below.
// Depends on lbbt_pkg.
module lbbt_checker
  import lbbt_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire in_item_t  in_item,
  input wire logic      out_strobe,
  input wire out_item_t out_item
);

  // Every result comes from an accepted query word that passed through stage 1 and the output register.
  a_strobe_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && in_item.action == ACT_QUERY, 2))
    else $error("result word without a matching query");

  // A query accepted outside reset is always answered.
  a_query_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.action == ACT_QUERY) ##1 rst_n |=> out_strobe)
    else $error("query word was not answered");

  // An unseen label reports no floating flag and zero bounds.
  a_unseen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.seen |-> out_item.floating == 1'b0 &&
      out_item.min_x == '0 && out_item.min_y == '0 && out_item.min_z == '0 &&
      out_item.max_x == '0 && out_item.max_y == '0 && out_item.max_z == '0)
    else $error("unseen label with nonzero bounds");

  // Label zero is never recorded.
  a_label_zero_unseen: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && $past(in_item.label, 2) == '0 |-> !out_item.seen)
    else $error("label zero reported as seen");

endmodule : lbbt_checker

bind label_bounding_box_tracker_core lbbt_checker u_lbbt_checker (.*);
`default_nettype wire
